@@ hdl/erot_pkg.sv @@
// ----------------------------------------------------------------------------
// erot_pkg
// Shared widths, coefficient types and trig helpers for the euler rotator:
// quarter-wave sine table built at elaboration, angle folding, rounding and
// saturation of one rotated coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

package erot_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int ANGLE_WIDTH    = 9;
  localparam int CFG_INDEX_WIDTH = 2;

  // magnitude of sin in 0..1.0, and signed coefficient holding +-1.0
  localparam int TRIG_MAG_WIDTH = TRIG_FRAC_BITS + 1;
  localparam int COEF_WIDTH     = TRIG_MAG_WIDTH + 1;
  localparam int PROD_WIDTH     = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH      = PROD_WIDTH + 1;
  localparam int SHIFT_WIDTH    = SUM_WIDTH - TRIG_FRAC_BITS;

  localparam int QUARTER_DEG       = 90;
  localparam int QUARTER_IDX_WIDTH = $clog2(QUARTER_DEG + 1);

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_Z = 2'd2;

  localparam logic [ANGLE_WIDTH-1:0] DEG_90  = ANGLE_WIDTH'(90);
  localparam logic [ANGLE_WIDTH-1:0] DEG_180 = ANGLE_WIDTH'(180);
  localparam logic [ANGLE_WIDTH-1:0] DEG_270 = ANGLE_WIDTH'(270);
  localparam logic [ANGLE_WIDTH-1:0] DEG_360 = ANGLE_WIDTH'(360);
  localparam logic [ANGLE_WIDTH-1:0] DEG_450 = ANGLE_WIDTH'(450);

  // taylor series constants; pi, one, the divisors and the rounding term are in Q30
  localparam int    Q30_BITS      = 30;
  localparam longint ONE_Q30      = longint'(1) <<< Q30_BITS;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint HALF_TURN_DEG = 180;
  localparam int    TAYLOR_TERMS  = 7;
  localparam longint TAYLOR_DIV [1:TAYLOR_TERMS] = '{
    6 * ONE_Q30, 20 * ONE_Q30, 42 * ONE_Q30, 72 * ONE_Q30,
    110 * ONE_Q30, 156 * ONE_Q30, 210 * ONE_Q30
  };
  localparam longint TRIG_ROUND_Q30 = longint'(1) <<< (Q30_BITS - TRIG_FRAC_BITS - 1);

  localparam logic signed [SUM_WIDTH-1:0] ROUND_HALF =
    SUM_WIDTH'(longint'(1) <<< (TRIG_FRAC_BITS - 1));
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic [TRIG_MAG_WIDTH-1:0] sin_table_t [0:QUARTER_DEG];

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] c;
    logic signed [COEF_WIDTH-1:0] s;
    logic signed [COEF_WIDTH-1:0] ns;
  } coef_t;

  // sin(d deg) for d in 0..90, taylor series in Q30, rounded half up
  function automatic sin_table_t build_sin_table();
    sin_table_t tbl;
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int d = 0; d <= QUARTER_DEG; d++) begin
      x    = (longint'(d) * PI_Q30 + HALF_TURN_DEG / 2) / HALF_TURN_DEG;
      x2   = (x * x) >>> Q30_BITS;
      term = x;
      sum  = x;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = -(term * x2) / TAYLOR_DIV[k];
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      tbl[d] = TRIG_MAG_WIDTH'((sum + TRIG_ROUND_Q30) >>> (Q30_BITS - TRIG_FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam sin_table_t SIN_TABLE = build_sin_table();

  // fold 360..511 back into range
  function automatic logic [ANGLE_WIDTH-1:0] reduce_angle(input logic [ANGLE_WIDTH-1:0] a);
    return (a >= DEG_360) ? a - DEG_360 : a;
  endfunction

  // signed sine of a folded angle from the quarter-wave table
  function automatic logic signed [COEF_WIDTH-1:0] sin_deg(input logic [ANGLE_WIDTH-1:0] a);
    logic [ANGLE_WIDTH-1:0]    idx;
    logic                      neg;
    logic [TRIG_MAG_WIDTH-1:0] mag;
    logic signed [COEF_WIDTH-1:0] val;
    if (a <= DEG_90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= DEG_180) begin
      idx = DEG_180 - a;
      neg = 1'b0;
    end else if (a <= DEG_270) begin
      idx = a - DEG_180;
      neg = 1'b1;
    end else begin
      idx = DEG_360 - a;
      neg = 1'b1;
    end
    mag = SIN_TABLE[idx[QUARTER_IDX_WIDTH-1:0]];
    val = signed'({1'b0, mag});
    return neg ? -val : val;
  endfunction

  // (p1 + p2) / 2^frac, ties toward +inf, clamped to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] round_sat(
    input logic signed [PROD_WIDTH-1:0] p1,
    input logic signed [PROD_WIDTH-1:0] p2
  );
    logic signed [SUM_WIDTH-1:0]   sum;
    logic signed [SHIFT_WIDTH-1:0] q;
    logic [SHIFT_WIDTH-COORD_WIDTH:0] top;
    sum = SUM_WIDTH'(p1) + SUM_WIDTH'(p2) + ROUND_HALF;
    q   = SHIFT_WIDTH'(sum >>> TRIG_FRAC_BITS);
    top = q[SHIFT_WIDTH-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      return q[COORD_WIDTH-1:0];
    end else if (q[SHIFT_WIDTH-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/erot_coef.sv @@
// ----------------------------------------------------------------------------
// erot_coef
// Turns one angle register into registered cos, sin and -sin coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module erot_coef (
  input  wire logic                             clk,
  input  wire logic [erot_pkg::ANGLE_WIDTH-1:0] angle,
  output erot_pkg::coef_t                       coef
);

  logic [erot_pkg::ANGLE_WIDTH-1:0] folded;
  logic [erot_pkg::ANGLE_WIDTH-1:0] cos_angle;
  erot_pkg::coef_t                  coef_next;

  always_comb begin
    folded    = erot_pkg::reduce_angle(angle);
    // cos(a) = sin(90 - a), wrapped into 0..359
    cos_angle = (folded <= erot_pkg::DEG_90) ? erot_pkg::DEG_90 - folded
                                             : erot_pkg::DEG_450 - folded;
    coef_next.c  = erot_pkg::sin_deg(cos_angle);
    coef_next.s  = erot_pkg::sin_deg(folded);
    coef_next.ns = -coef_next.s;
  end

  always_ff @(posedge clk) begin
    coef <= coef_next;
  end

endmodule

`default_nettype wire

@@ hdl/erot_stage.sv @@
// ----------------------------------------------------------------------------
// erot_stage
// One plane rotation as two pipeline steps: four products, then
// sum, round and saturate. u' = c*u + s*v, v' = -s*u + c*v, w passes.
// ----------------------------------------------------------------------------
`default_nettype none

module erot_stage (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire erot_pkg::coef_t                         coef,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0] in_u,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0] in_v,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0] in_w,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]      out_u,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]      out_v,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]      out_w
);

  // product step
  logic                                     mul_valid;
  logic                                     mul_ready;
  logic signed [erot_pkg::PROD_WIDTH-1:0]   cu;
  logic signed [erot_pkg::PROD_WIDTH-1:0]   sv;
  logic signed [erot_pkg::PROD_WIDTH-1:0]   nsu;
  logic signed [erot_pkg::PROD_WIDTH-1:0]   cv;
  logic signed [erot_pkg::COORD_WIDTH-1:0]  mul_w;

  logic in_fire;
  logic mul_fire;

  assign mul_ready = !out_valid || out_ready;
  assign in_ready  = !mul_valid || mul_ready;
  assign in_fire   = in_valid && in_ready;
  assign mul_fire  = mul_valid && mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        mul_valid <= in_valid;
      end
      if (mul_ready) begin
        out_valid <= mul_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cu    <= erot_pkg::PROD_WIDTH'(in_u) * erot_pkg::PROD_WIDTH'(coef.c);
      sv    <= erot_pkg::PROD_WIDTH'(in_v) * erot_pkg::PROD_WIDTH'(coef.s);
      nsu   <= erot_pkg::PROD_WIDTH'(in_u) * erot_pkg::PROD_WIDTH'(coef.ns);
      cv    <= erot_pkg::PROD_WIDTH'(in_v) * erot_pkg::PROD_WIDTH'(coef.c);
      mul_w <= in_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_fire) begin
      out_u <= erot_pkg::round_sat(cu, sv);
      out_v <= erot_pkg::round_sat(nsu, cv);
      out_w <= mul_w;
    end
  end

endmodule

`default_nettype wire

@@ hdl/euler_xyz_point_rotator.sv @@
// ----------------------------------------------------------------------------
// euler_xyz_point_rotator
// Rotates a stream of Q16.16 points about X, then Y, then Z by three
// whole-degree angles held in configuration registers.
// ----------------------------------------------------------------------------
// usage
//   input beats (in_x, in_y, in_z) arrive on a valid/ready channel, one
//   rotated point leaves per beat on out_valid/out_ready (out_x/y/z)
//   angles are written through cfg_we/cfg_index/cfg_data while no beat is
//   in flight: index 0 = x, 1 = y, 2 = z; other indexes are ignored
//   values 360..511 are folded down by 360
// timing
//   six register steps: two per axis (products, then round and saturate)
//   throughput is one point per clock while out_ready is high, set by the
//   four multipliers of each axis step working on a new point every cycle
//   sin/cos coefficients load at the same edge as the angle write, so the
//   very next input beat is already rotated by the new angles
// reset and stalls
//   rst clears all angles to zero and empties the pipeline
//   when out_ready is low each step holds its beat; empty steps keep
//   filling, so in_ready drops only once all six steps are occupied
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_point_rotator (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  // configuration
  input  wire logic                                        cfg_we,
  input  wire logic [erot_pkg::CFG_INDEX_WIDTH-1:0]        cfg_index,
  input  wire logic [erot_pkg::ANGLE_WIDTH-1:0]            cfg_data,
  // input points
  input  wire logic                                        in_valid,
  output logic                                             in_ready,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0]     in_x,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0]     in_y,
  input  wire logic signed [erot_pkg::COORD_WIDTH-1:0]     in_z,
  // rotated points
  output logic                                             out_valid,
  input  wire logic                                        out_ready,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]          out_x,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]          out_y,
  output logic signed [erot_pkg::COORD_WIDTH-1:0]          out_z
);

  // angle registers
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_x_deg;
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_y_deg;
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_z_deg;
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_x_next;
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_y_next;
  logic [erot_pkg::ANGLE_WIDTH-1:0] angle_z_next;

  always_comb begin
    angle_x_next = angle_x_deg;
    angle_y_next = angle_y_deg;
    angle_z_next = angle_z_deg;
    if (rst) begin
      angle_x_next = '0;
      angle_y_next = '0;
      angle_z_next = '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        erot_pkg::REG_ANGLE_X: angle_x_next = cfg_data;
        erot_pkg::REG_ANGLE_Y: angle_y_next = cfg_data;
        erot_pkg::REG_ANGLE_Z: angle_z_next = cfg_data;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    angle_x_deg <= angle_x_next;
    angle_y_deg <= angle_y_next;
    angle_z_deg <= angle_z_next;
  end

  // per-axis coefficients, loaded together with the angle registers
  erot_pkg::coef_t coef_x;
  erot_pkg::coef_t coef_y;
  erot_pkg::coef_t coef_z;
  erot_pkg::coef_t coef_y_swap;

  erot_coef u_coef_x (.clk(clk), .angle(angle_x_next), .coef(coef_x));
  erot_coef u_coef_y (.clk(clk), .angle(angle_y_next), .coef(coef_y));
  erot_coef u_coef_z (.clk(clk), .angle(angle_z_next), .coef(coef_z));

  // the y rotation runs the other way round in the (x, z) plane:
  // x' = c*x - s*z, z' = s*x + c*z
  always_comb begin
    coef_y_swap.c  = coef_y.c;
    coef_y_swap.s  = coef_y.ns;
    coef_y_swap.ns = coef_y.s;
  end

  // x axis: rotate (y, z), x passes
  logic                                    x_valid;
  logic                                    x_ready;
  logic signed [erot_pkg::COORD_WIDTH-1:0] x_stage_x;
  logic signed [erot_pkg::COORD_WIDTH-1:0] x_stage_y;
  logic signed [erot_pkg::COORD_WIDTH-1:0] x_stage_z;

  erot_stage u_rot_x (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef_x),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_u      (in_y),
    .in_v      (in_z),
    .in_w      (in_x),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .out_u     (x_stage_y),
    .out_v     (x_stage_z),
    .out_w     (x_stage_x)
  );

  // y axis: rotate (x, z), y passes
  logic                                    y_valid;
  logic                                    y_ready;
  logic signed [erot_pkg::COORD_WIDTH-1:0] y_stage_x;
  logic signed [erot_pkg::COORD_WIDTH-1:0] y_stage_y;
  logic signed [erot_pkg::COORD_WIDTH-1:0] y_stage_z;

  erot_stage u_rot_y (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef_y_swap),
    .in_valid  (x_valid),
    .in_ready  (x_ready),
    .in_u      (x_stage_x),
    .in_v      (x_stage_z),
    .in_w      (x_stage_y),
    .out_valid (y_valid),
    .out_ready (y_ready),
    .out_u     (y_stage_x),
    .out_v     (y_stage_z),
    .out_w     (y_stage_y)
  );

  // z axis: rotate (x, y), z passes; its output registers face the receiver
  erot_stage u_rot_z (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef_z),
    .in_valid  (y_valid),
    .in_ready  (y_ready),
    .in_u      (y_stage_x),
    .in_v      (y_stage_y),
    .in_w      (y_stage_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_u     (out_x),
    .out_v     (out_y),
    .out_w     (out_z)
  );

endmodule

`default_nettype wire
